// File: design/wks_pkg.sv
// ----------------------------------------------------------------------------
// wks_pkg: shared types and codes for the weighted KS statistic block
// Field widths, request kinds and payload structs used by the interfaces and the statistic block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wks_pkg;

	localparam int POS_W    = 32;
	localparam int WEIGHT_W = 25;
	localparam int STAT_W   = 25;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_LOAD_REF   = 2'd0;
	localparam kind_t KIND_LOAD_TRIAL = 2'd1;
	localparam kind_t KIND_COMPUTE    = 2'd2;

	typedef struct packed {
		kind_t                    kind;
		logic signed [POS_W-1:0]  position;
		logic [WEIGHT_W-1:0]      weight;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] statistic;
		logic              empty_error;
	} out_item_t;

	// one stored sample
	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic [WEIGHT_W-1:0]     weight;
	} sample_t;

	localparam int SAMPLE_W = $bits(sample_t);

endpackage

// File: design/wks_in_if.sv
// ----------------------------------------------------------------------------
// wks_in_if: request channel of the weighted KS statistic block
// Valid/ready handshake carrying one load or compute request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wks_in_if;
	import wks_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/wks_out_if.sv
// ----------------------------------------------------------------------------
// wks_out_if: result channel of the weighted KS statistic block
// Valid/ready handshake carrying one statistic and its empty flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wks_out_if;
	import wks_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/weighted_ks_statistic.sv
// ----------------------------------------------------------------------------
// weighted_ks_statistic: weighted two-sample Kolmogorov-Smirnov statistic
// Usage:
//   samples (sink): kind 0 appends {position, weight} to the reference list,
//     kind 1 to the trial list, kind 2 computes the statistic and empties
//     both lists; kind 3 is dropped. Lists are expected in ascending order.
//     A load into a full list is dropped.
//   results (source): one result per compute: statistic (Q1.24, saturated)
//     and empty_error, set when either list was empty.
//   Loads are accepted back to back while idle. A compute runs a select
//   state (PICK), then one walk step per cycle (lead list length minus one,
//   plus the other-list samples walked), then the drain states DRAIN1 and
//   DRAIN2 settle the running maximum and a finish state posts the result.
//   The rate is set by the walk reading one sample per list per cycle from
//   the two sample RAMs. An empty-list compute skips to the finish state.
//   Requests are taken only between computes.
//   Reset empties both lists and clears the result register; RAM contents
//   are not cleared (only loaded entries are ever used).
//   A stalled result waits in the output register; loads keep flowing, and
//   the next compute holds its result until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_ks_statistic #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	wks_in_if.sink      samples,
	wks_out_if.source   results
);
	import wks_pkg::*;

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int CNTW = $clog2(MAX_SAMPLES + 1);
	// cumulative weight never exceeds MAX_SAMPLES * 2^WEIGHT_W
	localparam int CW   = AW + WEIGHT_W + 1;
	localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_SAMPLES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_WALK,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] ref_count_q, trial_count_q;
	logic            lead_trial_q;
	logic [CNTW-1:0] i_q, j_q;
	logic [CW-1:0]   c1_q, c2_q;
	logic            upd_q;
	logic [CW-1:0]   diff_s1;
	logic            dv_s1;
	logic [CW-1:0]   best_q;
	logic            err_q;
	logic            out_valid_q;
	out_item_t       out_data_q;

	logic            acc;
	logic [SAMPLE_W-1:0] ref_rdata, trial_rdata;
	sample_t         ref_rd, trial_rd, lead_rd, other_rd;
	logic            pick_trial, lead_sel, take_other;
	logic [CNTW-1:0] lead_n, other_n, pick_lead_n;
	logic [CNTW-1:0] i_nx, j_nx;
	logic [AW-1:0]   ref_raddr, trial_raddr;
	logic            ref_we, trial_we;
	logic [CW-1:0]   gap;
	logic [STAT_W-1:0] stat_sat;
	sample_t         wr_sample;

	assign samples.ready = (state_q == ST_IDLE);
	assign acc           = samples.valid && samples.ready;

	// ---------------- sample storage ----------------
	assign wr_sample.position = samples.data.position;
	assign wr_sample.weight   = samples.data.weight;

	assign ref_we   = acc && (samples.data.kind == KIND_LOAD_REF) &&
	                  (ref_count_q < MAX_CNT);
	assign trial_we = acc && (samples.data.kind == KIND_LOAD_TRIAL) &&
	                  (trial_count_q < MAX_CNT);

	wks_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_count_q[AW-1:0]),
		.wdata (wr_sample),
		.raddr (ref_raddr),
		.rdata (ref_rdata)
	);

	wks_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_trial_ram (
		.clk   (clk),
		.we    (trial_we),
		.waddr (trial_count_q[AW-1:0]),
		.wdata (wr_sample),
		.raddr (trial_raddr),
		.rdata (trial_rdata)
	);

	assign ref_rd   = ref_rdata;
	assign trial_rd = trial_rdata;

	// ---------------- walk control ----------------
	// In PICK both RAMs show entry 0; trial leads on a tie.
	assign pick_trial  = !(ref_rd.position < trial_rd.position);
	assign pick_lead_n = pick_trial ? trial_count_q : ref_count_q;
	assign lead_sel    = (state_q == ST_PICK) ? pick_trial : lead_trial_q;

	assign lead_rd  = lead_trial_q ? trial_rd : ref_rd;
	assign other_rd = lead_trial_q ? ref_rd : trial_rd;
	assign lead_n   = lead_trial_q ? trial_count_q : ref_count_q;
	assign other_n  = lead_trial_q ? ref_count_q : trial_count_q;

	// bound test first, so a sample past the end is never used
	assign take_other = (j_q < other_n) && (other_rd.position < lead_rd.position);

	// Read address is the index of the sample needed next cycle, so the RAM
	// output always presents the current lead and other samples.
	always_comb begin
		i_nx = '0;
		j_nx = '0;
		unique case (state_q)
			ST_PICK: begin
				i_nx = CNTW'(1);
				j_nx = '0;
			end
			ST_WALK: begin
				i_nx = take_other ? i_q : CNTW'(i_q + 1'b1);
				j_nx = take_other ? CNTW'(j_q + 1'b1) : j_q;
			end
			default: begin
				i_nx = '0;
				j_nx = '0;
			end
		endcase
	end

	assign ref_raddr   = lead_sel ? j_nx[AW-1:0] : i_nx[AW-1:0];
	assign trial_raddr = lead_sel ? i_nx[AW-1:0] : j_nx[AW-1:0];

	// ---------------- running maximum ----------------
	assign gap      = (c1_q >= c2_q) ? (c1_q - c2_q) : (c2_q - c1_q);
	assign stat_sat = (|best_q[CW-1:STAT_W]) ? {STAT_W{1'b1}} : best_q[STAT_W-1:0];

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ref_count_q   <= '0;
			trial_count_q <= '0;
			lead_trial_q  <= 1'b0;
			i_q           <= '0;
			j_q           <= '0;
			c1_q          <= '0;
			c2_q          <= '0;
			upd_q         <= 1'b0;
			diff_s1       <= '0;
			dv_s1         <= 1'b0;
			best_q        <= '0;
			err_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			// gap of each new accumulator pair, then fold into the maximum
			upd_q   <= 1'b0;
			diff_s1 <= gap;
			dv_s1   <= upd_q;
			if (dv_s1 && (diff_s1 > best_q)) begin
				best_q <= diff_s1;
			end
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						priority case (samples.data.kind)
							KIND_LOAD_REF: begin
								if (ref_we) begin
									ref_count_q <= CNTW'(ref_count_q + 1'b1);
								end
							end
							KIND_LOAD_TRIAL: begin
								if (trial_we) begin
									trial_count_q <= CNTW'(trial_count_q + 1'b1);
								end
							end
							KIND_COMPUTE: begin
								if ((ref_count_q == '0) || (trial_count_q == '0)) begin
									err_q   <= 1'b1;
									state_q <= ST_FINISH;
								end else begin
									err_q   <= 1'b0;
									state_q <= ST_PICK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PICK: begin
					lead_trial_q <= pick_trial;
					c1_q   <= CW'(pick_trial ? trial_rd.weight : ref_rd.weight);
					c2_q   <= '0;
					upd_q  <= 1'b1;
					best_q <= '0;
					i_q    <= CNTW'(1);
					j_q    <= '0;
					state_q <= (pick_lead_n == CNTW'(1)) ? ST_DRAIN1 : ST_WALK;
				end
				ST_WALK: begin
					upd_q <= 1'b1;
					if (take_other) begin
						c2_q <= c2_q + CW'(other_rd.weight);
						j_q  <= CNTW'(j_q + 1'b1);
					end else begin
						c1_q <= c1_q + CW'(lead_rd.weight);
						i_q  <= CNTW'(i_q + 1'b1);
						if (CNTW'(i_q + 1'b1) == lead_n) begin
							state_q <= ST_DRAIN1;
						end
					end
				end
				ST_DRAIN1: begin
					state_q <= ST_DRAIN2;
				end
				ST_DRAIN2: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q            <= 1'b1;
						out_data_q.statistic   <= err_q ? '0 : stat_sat;
						out_data_q.empty_error <= err_q;
						ref_count_q            <= '0;
						trial_count_q          <= '0;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ref_count_q <= MAX_CNT) && (trial_count_q <= MAX_CNT))
		else $error("sample count beyond list depth");

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ((i_q < lead_n) && (j_q <= other_n)))
		else $error("walk index out of range");

	a_compute_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (samples.data.kind == KIND_COMPUTE) && (ref_count_q != '0) &&
		 (trial_count_q != '0)) |=> (state_q == ST_PICK))
		else $error("compute with loaded lists did not start the walk");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result posted outside finish");
`endif

endmodule

// File: design/wks_ram.sv
// ----------------------------------------------------------------------------
// wks_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
